// ===== src/sbo_pkg.sv =====
// shared types and constants of the select-before-operate controller
// used by the top level and sbo_chan_mem; no dependencies

package sbo_pkg;

  // command opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SELECT  = 3'd1;
  localparam logic [2:0] OP_EXECUTE = 3'd2;
  localparam logic [2:0] OP_CANCEL  = 3'd3;
  localparam logic [2:0] OP_DIRECT  = 3'd4;
  localparam logic [2:0] OP_TEST    = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_SELECT_ECHO = 3'd0;
  localparam logic [2:0] KIND_EXEC_ECHO   = 3'd1;
  localparam logic [2:0] KIND_DIRECT_ECHO = 3'd2;
  localparam logic [2:0] KIND_RELAY_UPD   = 3'd3;
  localparam logic [2:0] KIND_TEST_UPD    = 3'd4;
  localparam logic [2:0] KIND_TICK_DONE   = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
  localparam logic [2:0] ST_BUSY        = 3'd2;
  localparam logic [2:0] ST_VERIFY_FAIL = 3'd3;
  localparam logic [2:0] ST_SEL_TIMEOUT = 3'd4;

  // relay actions
  localparam logic [1:0] DRV_NONE     = 2'd0;
  localparam logic [1:0] DRV_ENERGIZE = 2'd1;
  localparam logic [1:0] DRV_RELEASE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_COUNT  = 2'd0;
  localparam logic [1:0] CFG_VERIFY_WAIT    = 2'd1;
  localparam logic [1:0] CFG_SELECT_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SELECTING = 3'd1,
    PH_SELECTED  = 3'd2,
    PH_EXECUTING = 3'd3,
    PH_DIRECT    = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] ticks;
  } chan_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  channel;
    logic [31:0] verify_bits;
    logic [15:0] hold_time_ms;
    logic [15:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  out_channel;
    logic [2:0]  status_code;
    logic [1:0]  pre_drive;
    logic [1:0]  exec_drive;
    logic [1:0]  test_drive;
    logic [15:0] echo_tag;
    logic        last;
  } out_item_t;

endpackage

// ===== src/select_before_operate_controller.sv =====
// top level of the select-before-operate relay controller: sequencer,
// config registers, test output state and output register; uses sbo_pkg,
// sbo_chan_mem and sbo_hold_div
//
//   port group     dir  handshake            payload
//   in_*           in   in_valid_i/in_stall_o  sbo_pkg::in_item_t
//   out_*          out  out_valid_o/out_stall_i sbo_pkg::out_item_t
//   cfg_*          in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a command is checked in S_CMD against the channel word read at accept; its echo
// is registered once the output is free, and S_IDLE then takes the next word
// a tick walks the channels in use one channel per cycle, unless a stalled output
// holds it, through the memory read-modify-write, then the test step and the
// tick-done word; the registered memory read sets the per-channel pace
// reset is asynchronous; channel memory reads as idle until written, no sweep
// a stalled output holds the sequencer wherever a word must be emitted

module select_before_operate_controller #(
  parameter int MAX_CHANNELS = 32,
  parameter int TICK_MS      = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sbo_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sbo_pkg::out_item_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMD  = 5'b00010,
    S_WALK = 5'b00100,
    S_TEST = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  sbo_pkg::in_item_t  item_q;
  logic [AW-1:0]      idx_q, idx_d;
  logic [5:0]         ch_count_q;
  logic [15:0]        verify_wait_q;
  logic [15:0]        sel_timeout_q;
  logic               test_active_q, test_active_d;
  logic [15:0]        test_ticks_q, test_ticks_d;
  logic [5:0]         test_channel_q, test_channel_d;
  logic               out_valid_q;
  sbo_pkg::out_item_t out_data_q;

  logic               accept;
  logic               out_free;
  logic               emit;
  sbo_pkg::out_item_t res;
  logic [5:0]         in_use;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  sbo_pkg::chan_state_t wr_data;
  sbo_pkg::chan_state_t rd_data;
  logic [15:0]        hold_ticks;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_use      = (ch_count_q > 6'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS) : ch_count_q;
  assign cfg_ready_o = 1'b1;

  sbo_chan_mem #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  sbo_hold_div #(
    .TICK_MS (TICK_MS)
  ) u_div (
    .clk_i   (clk_i),
    .en_i    (accept),
    .hold_i  (in_data_i.hold_time_ms),
    .ticks_o (hold_ticks)
  );

  always_comb begin
    logic ch_ok;
    logic vbit_cmd;
    logic vbit_walk;
    logic last_ch;
    logic adv;

    state_d        = state_q;
    idx_d          = idx_q;
    test_active_d  = test_active_q;
    test_ticks_d   = test_ticks_q;
    test_channel_d = test_channel_q;
    rd_en          = 1'b0;
    rd_addr        = in_data_i.channel[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = item_q.channel[AW-1:0];
    wr_data        = rd_data;
    emit           = 1'b0;
    res            = '0;
    res.echo_tag   = item_q.tag;
    res.out_channel = item_q.channel;
    res.last       = 1'b1;

    ch_ok     = item_q.channel < in_use;
    vbit_cmd  = item_q.verify_bits[item_q.channel[4:0]];
    vbit_walk = item_q.verify_bits[idx_q];
    last_ch   = (6'(idx_q) == (in_use - 6'd1));
    adv       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.opcode == sbo_pkg::OP_TICK) begin
            if (in_use == 6'd0) begin
              state_d = S_TEST;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              idx_d   = '0;
              state_d = S_WALK;
            end
          end else if (in_data_i.opcode <= sbo_pkg::OP_TEST) begin
            rd_en   = 1'b1;
            state_d = S_CMD;
          end
        end
      end

      S_CMD: begin
        case (item_q.opcode)
          sbo_pkg::OP_SELECT: begin
            res.kind = sbo_pkg::KIND_SELECT_ECHO;
            if (!ch_ok) begin
              res.status_code = sbo_pkg::ST_BAD_CHANNEL;
            end else if (rd_data.phase != sbo_pkg::PH_IDLE) begin
              res.status_code = sbo_pkg::ST_BUSY;
            end else if (vbit_cmd) begin
              res.pre_drive = sbo_pkg::DRV_ENERGIZE;
              wr_en         = 1'b1;
              wr_data.phase = sbo_pkg::PH_SELECTED;
              wr_data.ticks = sel_timeout_q;
            end else begin
              res.kind      = sbo_pkg::KIND_RELAY_UPD;
              res.pre_drive = sbo_pkg::DRV_ENERGIZE;
              wr_en         = 1'b1;
              wr_data.phase = sbo_pkg::PH_SELECTING;
              wr_data.ticks = verify_wait_q;
            end
          end
          sbo_pkg::OP_EXECUTE: begin
            res.kind = sbo_pkg::KIND_EXEC_ECHO;
            if (!ch_ok) begin
              res.status_code = sbo_pkg::ST_BAD_CHANNEL;
            end else if (rd_data.phase != sbo_pkg::PH_SELECTED) begin
              res.status_code = sbo_pkg::ST_BUSY;
            end else begin
              res.exec_drive = sbo_pkg::DRV_ENERGIZE;
              wr_en          = 1'b1;
              wr_data.phase  = sbo_pkg::PH_EXECUTING;
              wr_data.ticks  = hold_ticks;
            end
          end
          sbo_pkg::OP_CANCEL: begin
            res.kind = sbo_pkg::KIND_EXEC_ECHO;
            if (!ch_ok) begin
              res.status_code = sbo_pkg::ST_BAD_CHANNEL;
            end else if (rd_data.phase != sbo_pkg::PH_SELECTED &&
                         rd_data.phase != sbo_pkg::PH_SELECTING) begin
              res.status_code = sbo_pkg::ST_BUSY;
            end else begin
              res.pre_drive = sbo_pkg::DRV_RELEASE;
              wr_en         = 1'b1;
              wr_data.phase = sbo_pkg::PH_IDLE;
              wr_data.ticks = '0;
            end
          end
          sbo_pkg::OP_DIRECT: begin
            res.kind = sbo_pkg::KIND_DIRECT_ECHO;
            if (!ch_ok) begin
              res.status_code = sbo_pkg::ST_BAD_CHANNEL;
            end else if (rd_data.phase != sbo_pkg::PH_IDLE) begin
              res.status_code = sbo_pkg::ST_BUSY;
            end else begin
              res.pre_drive  = sbo_pkg::DRV_ENERGIZE;
              res.exec_drive = sbo_pkg::DRV_ENERGIZE;
              wr_en          = 1'b1;
              wr_data.phase  = sbo_pkg::PH_DIRECT;
              wr_data.ticks  = hold_ticks;
            end
          end
          default: begin
            // test drive, channel not range checked
            res.kind = sbo_pkg::KIND_TEST_UPD;
            if (test_active_q) begin
              res.status_code = sbo_pkg::ST_BUSY;
            end else if (out_free) begin
              res.test_drive = sbo_pkg::DRV_ENERGIZE;
              test_active_d  = 1'b1;
              test_ticks_d   = hold_ticks;
              test_channel_d = item_q.channel;
            end
          end
        endcase
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          wr_en = 1'b0;
        end
      end

      S_WALK: begin
        wr_addr         = idx_q;
        res.kind        = sbo_pkg::KIND_SELECT_ECHO;
        res.out_channel = 6'(idx_q);
        res.last        = 1'b0;
        case (rd_data.phase)
          sbo_pkg::PH_SELECTING: begin
            if (rd_data.ticks != 16'd0) begin
              if (vbit_walk) begin
                emit          = 1'b1;
                wr_data.phase = sbo_pkg::PH_SELECTED;
                wr_data.ticks = sel_timeout_q;
              end else begin
                wr_data.ticks = rd_data.ticks - 16'd1;
              end
            end else begin
              emit            = 1'b1;
              res.status_code = sbo_pkg::ST_VERIFY_FAIL;
              res.pre_drive   = sbo_pkg::DRV_RELEASE;
              wr_data.phase   = sbo_pkg::PH_IDLE;
            end
          end
          sbo_pkg::PH_SELECTED: begin
            if (rd_data.ticks == 16'd0) begin
              emit            = 1'b1;
              res.status_code = sbo_pkg::ST_SEL_TIMEOUT;
              res.pre_drive   = sbo_pkg::DRV_RELEASE;
              wr_data.phase   = sbo_pkg::PH_IDLE;
            end else begin
              wr_data.ticks = rd_data.ticks - 16'd1;
            end
          end
          sbo_pkg::PH_EXECUTING, sbo_pkg::PH_DIRECT: begin
            if (rd_data.ticks == 16'd0) begin
              emit           = 1'b1;
              res.kind       = sbo_pkg::KIND_RELAY_UPD;
              res.pre_drive  = sbo_pkg::DRV_RELEASE;
              res.exec_drive = sbo_pkg::DRV_RELEASE;
              wr_data.phase  = sbo_pkg::PH_IDLE;
            end else begin
              wr_data.ticks = rd_data.ticks - 16'd1;
            end
          end
          default: begin
          end
        endcase
        adv = !emit || out_free;
        if (!adv) begin
          emit = 1'b0;
        end else begin
          wr_en = 1'b1;
          if (last_ch) begin
            state_d = S_TEST;
          end else begin
            idx_d   = idx_q + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_q + AW'(1);
          end
        end
      end

      S_TEST: begin
        res.kind        = sbo_pkg::KIND_TEST_UPD;
        res.out_channel = test_channel_q;
        res.test_drive  = sbo_pkg::DRV_RELEASE;
        res.last        = 1'b0;
        if (test_active_q && test_ticks_q == 16'd0) begin
          if (out_free) begin
            emit          = 1'b1;
            test_active_d = 1'b0;
            state_d       = S_DONE;
          end
        end else begin
          if (test_active_q) begin
            test_ticks_d = test_ticks_q - 16'd1;
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res.kind        = sbo_pkg::KIND_TICK_DONE;
        res.out_channel = '0;
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (emit) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      idx_q          <= '0;
      ch_count_q     <= 6'd32;
      verify_wait_q  <= 16'd2;
      sel_timeout_q  <= 16'd3000;
      test_active_q  <= 1'b0;
      test_ticks_q   <= '0;
      test_channel_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      idx_q          <= idx_d;
      test_active_q  <= test_active_d;
      test_ticks_q   <= test_ticks_d;
      test_channel_q <= test_channel_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sbo_pkg::CFG_CHANNEL_COUNT:  ch_count_q    <= cfg_data_i[5:0];
          sbo_pkg::CFG_VERIFY_WAIT:    verify_wait_q <= cfg_data_i;
          sbo_pkg::CFG_SELECT_TIMEOUT: sel_timeout_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/sbo_chan_mem.sv =====
// per-channel phase and tick counter memory, registered read
// entries read as idle with zero ticks until first written; uses sbo_pkg

module sbo_chan_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  sbo_pkg::chan_state_t wr_data_i,
  output sbo_pkg::chan_state_t rd_data_o
);

  sbo_pkg::chan_state_t mem_q [DEPTH];
  sbo_pkg::chan_state_t rd_word_q;
  logic [DEPTH-1:0]     vld_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  // written flags stand in for clearing the array at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_word_q : '0;

endmodule

// ===== src/sbo_hold_div.sv =====
// hold time in ms to ticks: divide by TICK_MS through a reciprocal multiply
// product registered, quotient valid in the cycle after en_i; no dependencies

module sbo_hold_div #(
  parameter int TICK_MS = 10
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] hold_i,
  output logic [15:0] ticks_o
);

  localparam int  L     = $clog2(TICK_MS);
  localparam int  SHIFT = 16 + L;
  localparam longint MULT_FULL = ((longint'(1) << SHIFT) + TICK_MS - 1) / TICK_MS;
  localparam logic [16:0] MULT = 17'(MULT_FULL);

  logic [32:0] prod_q;
  logic [32:0] prod_d;

  assign prod_d = 33'(hold_i) * 33'(MULT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign ticks_o = 16'(prod_q >> SHIFT);

endmodule
